>>> rtl/dah_pkg.sv
// Shared types and constants for the ADPCM history advance block.
package dah_pkg;

  localparam int CHANNELS      = 2;
  localparam int COEF_BANKS    = 2;
  localparam int WORDS_PER_CH  = 4;
  localparam int NUM_REGS      = COEF_BANKS * WORDS_PER_CH;
  localparam int BLOCK_SAMPLES = 14;
  localparam int PRED_SHIFT    = 11;
  localparam int QDEPTH        = 2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int NIBBLES_W  = 56;
  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = $clog2(BLOCK_SAMPLES);
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One decode job handed from the front to the back.
  typedef struct packed {
    logic                 channel;
    sample_t              f1;
    sample_t              f2;
    logic [3:0]           expo;
    logic [NIBBLES_W-1:0] nibbles;
    logic                 eof;
  } job_t;

endpackage

>>> rtl/dah_if.sv
// Stream interfaces for ADPCM blocks in and channel history out.
interface dah_in_if;
  logic        valid;
  logic        ready;
  logic        channel;
  logic [2:0]  coef_pair;
  logic [3:0]  scale_exponent;
  logic [55:0] sample_nibbles;
  logic        end_of_frame;

  modport source (output valid, channel, coef_pair, scale_exponent, sample_nibbles,
                  end_of_frame, input ready);
  modport sink (input valid, channel, coef_pair, scale_exponent, sample_nibbles,
                end_of_frame, output ready);
endinterface

interface dah_out_if;
  logic               valid;
  logic               ready;
  logic               out_channel;
  logic signed [15:0] history_newest;
  logic signed [15:0] history_older;

  modport source (output valid, out_channel, history_newest, history_older, input ready);
  modport sink (input valid, out_channel, history_newest, history_older, output ready);
endinterface

>>> rtl/dah_front.sv
// Front end: coefficient registers, block intake and coefficient lookup.
module dah_front
  import dah_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dah_in_if.sink                blocks,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [CFG_DATA_W-1:0] coef [COEF_BANKS][WORDS_PER_CH];
  logic [CFG_DATA_W-1:0] word;
  logic [31:0]           half;
  logic                  ch_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < COEF_BANKS; b++) begin
        for (int w = 0; w < WORDS_PER_CH; w++) begin
          coef[b][w] <= '0;
        end
      end
    end else if (cfg_wr_en && (32'(cfg_index) < NUM_REGS)) begin
      coef[cfg_index[2]][cfg_index[1:0]] <= cfg_data;
    end
  end

  // Odd pairs sit in the low half of the word.
  assign word  = coef[blocks.channel][blocks.coef_pair[2:1]];
  assign half  = blocks.coef_pair[0] ? word[31:0] : word[63:32];
  assign ch_ok = (32'(blocks.channel) < CHANNELS);

  assign blocks.ready = !q_full;
  // Drop blocks for channels that are not present.
  assign q_push = blocks.valid && !q_full && ch_ok;

  always_comb begin
    q_job.channel = blocks.channel;
    q_job.f1      = sample_t'(half[31:16]);
    q_job.f2      = sample_t'(half[15:0]);
    q_job.expo    = blocks.scale_exponent;
    q_job.nibbles = blocks.sample_nibbles;
    q_job.eof     = blocks.end_of_frame;
  end

endmodule

>>> rtl/dah_queue.sv
// Short job queue between the front end and the decoder.
module dah_queue
  import dah_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t pop_job
);

  job_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_job   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QDEPTH)
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/dah_back.sv
// Back end: per-sample prediction recurrence, channel history and result register.
module dah_back
  import dah_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_not_empty,
  input  job_t      q_job,
  output logic      q_pop,
  dah_out_if.source history
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t               state;
  logic [CNT_W-1:0]     cnt;
  logic                 chan;
  sample_t              f1;
  sample_t              f2;
  logic [3:0]           expo;
  logic                 eof;
  logic [NIBBLES_W-1:0] nib_sr;
  sample_t              s1;
  sample_t              s2;
  sample_t              hist_new [CHANNELS];
  sample_t              hist_old [CHANNELS];

  logic                 out_valid;
  logic                 out_chan;
  sample_t              out_new;
  sample_t              out_old;

  logic signed [31:0]   prod1;
  logic signed [31:0]   prod2;
  logic signed [32:0]   acc;
  logic signed [21:0]   pred;
  logic signed [3:0]    nib;
  logic signed [18:0]   scaled;
  logic signed [22:0]   sum;
  sample_t              s_new;
  logic                 last;
  logic                 out_free;
  logic                 step_en;
  logic                 out_load;

  assign prod1  = s1 * f1;
  assign prod2  = s2 * f2;
  assign acc    = 33'(prod1) + 33'(prod2);
  // Arithmetic shift floors toward minus infinity.
  assign pred   = signed'(acc[32:PRED_SHIFT]);
  assign nib    = signed'(nib_sr[NIBBLES_W-1 -: 4]);
  assign scaled = 19'(nib) <<< expo;
  assign sum    = 23'(pred) + 23'(scaled);

  always_comb begin
    if (sum > 23'sd32767) begin
      s_new = 16'sh7fff;
    end else if (sum < -23'sd32768) begin
      s_new = -16'sh8000;
    end else begin
      s_new = sample_t'(sum);
    end
  end

  assign last     = (cnt == CNT_W'(BLOCK_SAMPLES - 1));
  assign out_free = !out_valid || history.ready;
  // Hold the final sample while a reported result is still waiting.
  assign step_en  = (state == RUN) && (!last || !eof || out_free);
  assign out_load = step_en && last && eof;
  assign q_pop    = (state == IDLE) && q_not_empty;

  assign history.valid          = out_valid;
  assign history.out_channel    = out_chan;
  assign history.history_newest = out_new;
  assign history.history_older  = out_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        hist_new[c] <= '0;
        hist_old[c] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (history.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_pop) begin
            chan   <= q_job.channel;
            f1     <= q_job.f1;
            f2     <= q_job.f2;
            expo   <= q_job.expo;
            eof    <= q_job.eof;
            nib_sr <= q_job.nibbles;
            s1     <= hist_new[q_job.channel];
            s2     <= hist_old[q_job.channel];
            cnt    <= '0;
            state  <= RUN;
          end
        end
        RUN: begin
          if (step_en) begin
            s1     <= s_new;
            s2     <= s1;
            nib_sr <= nib_sr << 4;
            cnt    <= cnt + 1'b1;
            if (last) begin
              hist_new[chan] <= s_new;
              hist_old[chan] <= s1;
              if (eof) begin
                out_chan  <= chan;
                out_new   <= s_new;
                out_old   <= s1;
              end
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (32'(cnt) < BLOCK_SAMPLES))
    else $error("sample counter out of range");

  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == RUN && last && eof))
    else $error("result raised outside the end of a block");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == RUN && cnt == '0))
    else $error("job pop did not start a block");
`endif

endmodule

>>> rtl/dsp_adpcm_history_advance.sv
// Top level of the ADPCM history advance block.
//
//  channel    dir  width  handshake        contents
//  cfg_*      in   64     cfg_wr_en        coefficient words, index 0..7
//  blocks     in   65     valid && ready   one 14-sample ADPCM block
//  history    out  33     valid && ready   channel history after end of frame
//
// A block passes through the decoder as a load step in IDLE and then one sample per
// cycle in RUN, set by the combinational prediction recurrence (two 16x16 products).
// A two-entry job queue lets intake run ahead of the decoder.
// Reset (rst, synchronous) clears coefficients, history, queue pointers and count, decoder state and output valid.
// The decoder holds its last sample while a reported history waits on ready.
module dsp_adpcm_history_advance
  import dah_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dah_in_if.sink                blocks,
  dah_out_if.source             history
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  job_t push_job;
  job_t pop_job;

  dah_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blocks    (blocks),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  dah_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (pop_job)
  );

  dah_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .history     (history)
  );

endmodule

>>> sim/tb_dsp_adpcm_history_advance.sv
// Self-checking testbench for the ADPCM history advance block.
`timescale 1ns / 1ps

module tb_dsp_adpcm_history_advance;
  import dah_pkg::*;

  localparam int PHASES           = 8;
  localparam int BLOCKS_PER_PHASE = 240;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int REPORT_LIMIT     = 10;

  localparam logic [NIBBLES_W-1:0] NIB_POS_MAX = {14{4'h7}};
  localparam logic [NIBBLES_W-1:0] NIB_NEG_MAX = {14{4'h8}};
  localparam logic [NIBBLES_W-1:0] NIB_NEG_ONE = {14{4'hF}};
  localparam logic [NIBBLES_W-1:0] NIB_MIXED   = {7{8'h78}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CH0_W0, REG_CH0_W1, REG_CH0_W2, REG_CH0_W3,
    REG_CH1_W0, REG_CH1_W1, REG_CH1_W2, REG_CH1_W3
  } coef_reg_e;

  localparam logic [CFG_IDX_W-1:0] REG_IDX_BEYOND = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP    = 4'd15;

  typedef enum int {COEF_TYPICAL, COEF_RANDOM, COEF_MAX, COEF_MIN} coef_style_e;

  typedef struct packed {
    logic                 channel;
    logic [2:0]           coef_pair;
    logic [3:0]           scale_exponent;
    logic [NIBBLES_W-1:0] sample_nibbles;
    logic                 end_of_frame;
  } block_t;

  typedef struct packed {
    logic    channel;
    sample_t newest;
    sample_t older;
  } history_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dah_in_if  blocks_if ();
  dah_out_if history_if ();

  dsp_adpcm_history_advance i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blocks    (blocks_if),
    .history   (history_if)
  );

  // Predictor state: coefficient shadow and per-channel history.
  logic [CFG_DATA_W-1:0] coef_bank [COEF_BANKS][WORDS_PER_CH];
  sample_t               hist_new  [CHANNELS];
  sample_t               hist_old  [CHANNELS];

  block_t   block_queue[$];
  history_t history_expected[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int error_count;
  int quiet_cycles;
  logic blk_took;
  history_t hist_want;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run one block through the decode recurrence and queue its history if reported.
  task automatic decode_block(input block_t blk);
    logic [CFG_DATA_W-1:0] word;
    longint f1, f2, s1, s2, acc, pred, nib;
    logic [3:0] raw;
    word = coef_bank[blk.channel][blk.coef_pair[2:1]];
    if (blk.coef_pair[0]) begin
      f1 = longint'(sample_t'(word[31:16]));
      f2 = longint'(sample_t'(word[15:0]));
    end else begin
      f1 = longint'(sample_t'(word[63:48]));
      f2 = longint'(sample_t'(word[47:32]));
    end
    s1 = longint'(hist_new[blk.channel]);
    s2 = longint'(hist_old[blk.channel]);
    for (int n = 0; n < BLOCK_SAMPLES; n++) begin
      raw  = blk.sample_nibbles[NIBBLES_W-1-4*n -: 4];
      nib  = longint'($signed(raw));
      acc  = s1 * f1 + s2 * f2;
      pred = (acc >>> PRED_SHIFT) + (nib <<< blk.scale_exponent);
      s2   = s1;
      if (pred > 32767) s1 = 32767;
      else if (pred < -32768) s1 = -32768;
      else s1 = pred;
    end
    hist_new[blk.channel] = sample_t'(s1);
    hist_old[blk.channel] = sample_t'(s2);
    if (blk.end_of_frame) begin
      history_expected.push_back({blk.channel, sample_t'(s1), sample_t'(s2)});
    end
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < NUM_REGS) coef_bank[idx[2]][idx[1:0]] = val;
  endtask

  function automatic logic [CFG_DATA_W-1:0] coef_word(input coef_style_e style);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      case (style)
        COEF_TYPICAL: w[16*k +: 16] = 16'($urandom_range(0, 8191)) - 16'd4096;
        COEF_MAX:     w[16*k +: 16] = 16'h7FFF;
        COEF_MIN:     w[16*k +: 16] = 16'h8000;
        default:      w[16*k +: 16] = 16'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic push_block(input logic ch, input logic [2:0] pair, input logic [3:0] expo,
                            input logic [NIBBLES_W-1:0] nib, input logic eof);
    block_queue.push_back({ch, pair, expo, nib, eof});
  endtask

  function automatic block_t random_block();
    block_t blk;
    int pick;
    blk.channel        = 1'($urandom_range(0, 1));
    blk.coef_pair      = 3'($urandom_range(0, 7));
    blk.scale_exponent = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 4))
                                                     : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) blk.sample_nibbles = NIB_POS_MAX;
    else if (pick == 1) blk.sample_nibbles = NIB_NEG_MAX;
    else blk.sample_nibbles = NIBBLES_W'({$urandom, $urandom});
    blk.end_of_frame = ($urandom_range(0, 2) == 0);
    return blk;
  endfunction

  // Hold until every beat is out, then let the decoder finish blocks with no report.
  task automatic wait_drained();
    while (block_queue.size() != 0 || history_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: present the queue head, drop it and predict once the beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      blocks_if.valid <= 1'b0;
    end else begin
      blk_took = blocks_if.valid && blocks_if.ready;
      if (blk_took) begin
        decode_block(block_queue[0]);
        void'(block_queue.pop_front());
      end
      if (!blocks_if.valid || blk_took) begin
        if (block_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          blocks_if.valid          <= 1'b1;
          blocks_if.channel        <= block_queue[0].channel;
          blocks_if.coef_pair      <= block_queue[0].coef_pair;
          blocks_if.scale_exponent <= block_queue[0].scale_exponent;
          blocks_if.sample_nibbles <= block_queue[0].sample_nibbles;
          blocks_if.end_of_frame   <= block_queue[0].end_of_frame;
        end else begin
          blocks_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      history_if.ready <= 1'b0;
      hold_left        <= 0;
      hold_seen        <= 0;
    end else if (hold_left != 0) begin
      history_if.ready <= 1'b0;
      hold_left        <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      history_if.ready <= 1'b0;
      hold_seen        <= hold_req;
      hold_left        <= HOLD_CYCLES;
    end else begin
      history_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && history_if.valid && history_if.ready) begin
      if (history_expected.size() == 0) begin
        report_error($sformatf("unexpected history beat: ch=%0d newest=%0d older=%0d",
                               history_if.out_channel, history_if.history_newest,
                               history_if.history_older));
      end else begin
        hist_want = history_expected.pop_front();
        if (history_if.out_channel !== hist_want.channel ||
            history_if.history_newest !== hist_want.newest ||
            history_if.history_older !== hist_want.older) begin
          report_error($sformatf(
              "expected ch=%0d new=%0d old=%0d, got ch=%0d new=%0d old=%0d",
              hist_want.channel, hist_want.newest, hist_want.older,
              history_if.out_channel, history_if.history_newest,
              history_if.history_older));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (blocks_if.valid && blocks_if.ready) ||
        (history_if.valid && history_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    block_t blk;
    rst                      = 1'b1;
    cfg_wr_en                = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    blocks_if.valid          = 1'b0;
    blocks_if.channel        = 1'b0;
    blocks_if.coef_pair      = '0;
    blocks_if.scale_exponent = '0;
    blocks_if.sample_nibbles = '0;
    blocks_if.end_of_frame   = 1'b0;
    history_if.ready         = 1'b0;
    send_idle_pct            = 0;
    recv_stall_pct           = 0;
    hold_req                 = 0;
    error_count              = 0;
    quiet_cycles             = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      hist_new[c] = '0;
      hist_old[c] = '0;
    end
    for (int b = 0; b < COEF_BANKS; b++) begin
      for (int w = 0; w < WORDS_PER_CH; w++) coef_bank[b][w] = '0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset coefficients: prediction is zero, large exponents saturate.
    push_block(1'b0, 3'd0, 4'd15, NIB_POS_MAX, 1'b0);
    push_block(1'b0, 3'd5, 4'd15, NIB_NEG_MAX, 1'b1);
    push_block(1'b1, 3'd7, 4'd0, NIB_MIXED, 1'b1);
    push_block(1'b1, 3'd2, 4'd3, '0, 1'b1);
    wait_drained();

    write_reg(REG_CH0_W0, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    write_reg(REG_CH0_W1, {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
    write_reg(REG_CH0_W2, {16'h0800, 16'h0000, 16'h1000, 16'hF800});
    write_reg(REG_CH0_W3, {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
    write_reg(REG_CH1_W0, coef_word(COEF_TYPICAL));
    write_reg(REG_CH1_W1, coef_word(COEF_TYPICAL));
    write_reg(REG_CH1_W2, coef_word(COEF_RANDOM));
    write_reg(REG_CH1_W3, {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF});
    // Writes beyond the register file must leave the coefficients alone.
    write_reg(REG_IDX_BEYOND, '1);
    write_reg(REG_IDX_TOP, '1);
    @(negedge clk);

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: push_block(1'b0, 3'(p), (p == 0) ? 4'd0 : 4'd9, NIB_POS_MAX, p[0]);
        1: push_block(1'b0, 3'(p), 4'd15, NIB_NEG_MAX, p[0]);
        2: push_block(1'b0, 3'(p), 4'd2, NIB_NEG_ONE, p[0]);
        default: push_block(1'b0, 3'(p), (p == 7) ? 4'd15 : 4'd5, NIB_MIXED, p[0]);
      endcase
    end
    for (int p = 0; p < 8; p++) begin
      push_block(1'b1, 3'(p), 4'($urandom_range(0, 15)), NIBBLES_W'({$urandom, $urandom}), 1'b1);
    end
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        write_reg(CFG_IDX_W'(r), coef_word((ph < 4) ? coef_style_e'(ph)
                                                    : coef_style_e'($urandom_range(0, 3))));
      end
      @(negedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int k = 0; k < BLOCKS_PER_PHASE; k++) begin
        blk = random_block();
        if (k == BLOCKS_PER_PHASE - 1) blk.end_of_frame = 1'b1;
        block_queue.push_back(blk);
      end
      // Back up the output while the sender keeps offering beats.
      if (ph == 0) hold_req++;
      wait_drained();
    end

    if (error_count == 0 && history_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
